// ===== src/flow_header_rewrite_engine_top_macros.svh =====
// Assertion macros shared by the files that assert.
`ifndef FLOW_HEADER_REWRITE_ENGINE_TOP_MACROS_SVH
`define FLOW_HEADER_REWRITE_ENGINE_TOP_MACROS_SVH
// Concurrent assertion on the rising edge, disabled during reset.
`define FHR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent assertion that also holds during reset.
`define FHR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/fhr_pkg.sv =====
// ---------------------------------------------------------------------------
// fhr_pkg
// Types and constants of the flow header rewrite engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package fhr_pkg;
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_TCP   = 8'h06;
    localparam logic [15:0] EGRESS_ADJ  = 16'h0600;
    localparam logic [15:0] STRIP_BYTES = 16'd16;

    typedef enum logic [1:0] {
        ACT_PASS  = 2'd0,
        ACT_DECAP = 2'd1,
        ACT_EGR   = 2'd2
    } t_action;

    typedef struct packed {
        logic        command;
        logic        frame_long_enough;
        logic [15:0] ethertype;
        logic [31:0] udp_ports;
        logic [31:0] ip_saddr;
        logic [31:0] ip_daddr;
        logic [15:0] ip_total_length;
        logic [15:0] ip_ttl_protocol;
        logic [15:0] ip_checksum;
        logic [31:0] tcp_ports;
        logic [15:0] tcp_checksum;
        logic [63:0] proxy_addrs;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] new_saddr;
        logic [31:0] new_daddr;
        logic [15:0] new_total_length;
        logic [7:0]  new_protocol;
        logic [15:0] new_ip_checksum;
        logic [15:0] new_tcp_checksum;
        logic        table_full;
    } t_out_word;

    // One checksum update job for the shared unit.
    typedef struct packed {
        logic [15:0] chk;
        logic [31:0] oldw;
        logic [31:0] neww;
        logic        is_long;
    } t_csum_req;
endpackage

// ===== src/fhr_stream_if.sv =====
// ---------------------------------------------------------------------------
// fhr_stream_if
// Valid/ready channel carrying one word of a given type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fhr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fhr_ram.sv =====
// ---------------------------------------------------------------------------
// fhr_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fhr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/fhr_csum.sv =====
// ---------------------------------------------------------------------------
// fhr_csum
// Shared incremental checksum unit, single fold, one job per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module fhr_csum (
    input  fhr_pkg::t_csum_req i_req,
    output logic [15:0]        o_chk
);
    import fhr_pkg::*;
    logic [31:0] w_o;
    logic [18:0] w_sum;
    logic [16:0] w_fold;
    always_comb begin
        w_o = ~i_req.oldw;
        if (i_req.is_long) begin
            w_sum = {3'b0, ~i_req.chk} + {3'b0, w_o[31:16]} + {3'b0, w_o[15:0]}
                  + {3'b0, i_req.neww[31:16]} + {3'b0, i_req.neww[15:0]};
        end else begin
            w_sum = {3'b0, ~i_req.chk} + {3'b0, w_o[15:0]} + {3'b0, i_req.neww[15:0]};
        end
        w_fold = {14'b0, w_sum[18:16]} + {1'b0, w_sum[15:0]};
        o_chk  = ~w_fold[15:0];
    end
endmodule

// ===== src/flow_header_rewrite_engine_top.sv =====
// ---------------------------------------------------------------------------
// flow_header_rewrite_engine_top
// NAT header rewrite with incremental checksums and a flow table.
// ---------------------------------------------------------------------------
// One parsed header enters as a word on i_in; one result word leaves on o_out.
// The block works on one word at a time: i_in.ready is high only while the
// sequencer is idle. Every word first scans the flow table entry by entry, one
// RAM read per cycle, over one RAM port. An ingress word that decapsulates then
// runs five checksum updates through the single shared checksum unit and
// writes the table; an egress hit fetches the stored address pair, runs four
// updates and then the final adjustment. After reset all valid bits are clear
// at once, so no clearing pass is needed.
// A finished result moves into the output register and waits there for the
// receiver while the next word is processed. If a second result is ready before
// the first is taken, the sequencer waits in its output state and the input
// stays closed, so a stalled receiver simply holds the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flow_header_rewrite_engine_top_macros.svh"
module flow_header_rewrite_engine_top #(
    parameter int FLOW_ENTRIES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fhr_stream_if.sink   i_in,
    fhr_stream_if.source o_out
);
    import fhr_pkg::*;
    localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam logic [AW:0] LAST = (AW+1)'(FLOW_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_CSUM = 6'b000100,
        S_WRT  = 6'b001000,
        S_EGRD = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_in_word r_in;
    t_out_word r_out;
    t_out_word r_res;
    logic r_ovalid;
    logic [FLOW_ENTRIES-1:0] r_valid;
    logic [AW:0] r_idx;        // scan counter, one wider to reach the depth
    logic [AW-1:0] r_hit, r_free;
    logic r_hit_ok, r_free_ok, r_rd_pend;
    logic [AW-1:0] r_rd_idx;
    logic [2:0] r_step;
    logic [63:0] r_orig;

    // Memory interface
    logic           w_we;
    logic [AW-1:0]  w_addr;
    logic [63:0]    w_key_rd, w_orig_rd, w_key_wr;
    logic [63:0]    w_lookup_key;
    t_csum_req      w_req;
    logic [15:0]    w_chk;
    logic           w_ingress, w_egress;
    logic [15:0]    w_newttlp;
    logic           w_out_load;

    fhr_ram #(.WIDTH(64), .DEPTH(FLOW_ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_key_wr), .o_rdata(w_key_rd));
    fhr_ram #(.WIDTH(64), .DEPTH(FLOW_ENTRIES)) u_orig (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_in.proxy_addrs), .o_rdata(w_orig_rd));
    fhr_csum u_csum (.i_req(w_req), .o_chk(w_chk));

    assign w_ingress = !r_in.command;
    assign w_egress  = r_in.command;
    assign w_newttlp = {r_in.ip_ttl_protocol[15:8], PROTO_TCP};
    assign w_key_wr  = {r_in.proxy_addrs[63:32], r_in.tcp_ports};
    assign w_lookup_key = w_ingress ? w_key_wr
        : {r_in.ip_daddr, r_in.tcp_ports[15:0], r_in.tcp_ports[31:16]};

    always_comb begin
        w_we = (r_state == S_WRT) && (r_hit_ok || r_free_ok);
        if (r_state == S_WRT) begin
            w_addr = r_hit_ok ? r_hit : r_free;
        end else if (r_state == S_EGRD || r_idx > LAST) begin
            // Once the scan has issued its last read, the hit entry is fetched
            // so that its address pair is ready in the egress read state.
            w_addr = r_hit;
        end else begin
            w_addr = r_idx[AW-1:0];
        end
    end

    // Checksum job selection per step.
    always_comb begin
        w_req = '0;
        if (w_ingress) begin
            case (r_step)
                3'd0: w_req = '{r_out.new_ip_checksum, r_in.ip_saddr,
                                r_in.proxy_addrs[63:32], 1'b1};
                3'd1: w_req = '{r_out.new_ip_checksum, {16'b0, r_in.ip_total_length},
                                {16'b0, r_out.new_total_length}, 1'b0};
                3'd2: w_req = '{r_out.new_ip_checksum, {16'b0, r_in.ip_ttl_protocol},
                                {16'b0, w_newttlp}, 1'b0};
                3'd3: w_req = '{r_out.new_tcp_checksum, r_in.proxy_addrs[63:32],
                                r_in.proxy_addrs[63:32], 1'b1};
                3'd4: w_req = '{r_out.new_tcp_checksum, r_in.proxy_addrs[31:0],
                                r_in.ip_daddr, 1'b1};
                default: w_req = '0;
            endcase
        end else begin
            case (r_step)
                3'd0: w_req = '{r_out.new_ip_checksum, r_in.ip_daddr,
                                r_orig[63:32], 1'b1};
                3'd1: w_req = '{r_out.new_ip_checksum, r_in.ip_saddr,
                                r_orig[31:0], 1'b1};
                3'd2: w_req = '{r_out.new_tcp_checksum, r_in.ip_daddr,
                                r_orig[63:32], 1'b1};
                3'd3: w_req = '{r_out.new_tcp_checksum, r_in.ip_saddr,
                                r_orig[31:0], 1'b1};
                default: w_req = '0;
            endcase
        end
    end

    // The output register can take a new result when it is empty or being read.
    assign w_out_load  = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in.valid && i_in.ready) n_state = S_SCAN;
            S_SCAN: begin
                // Leave once the last pending compare is done.
                if (!(r_idx <= LAST) && !r_rd_pend) begin
                    if (!r_in.frame_long_enough || r_in.ethertype != ETH_IPV4
                        || (w_ingress && r_in.udp_ports != 32'd0)) begin
                        n_state = S_OUT;
                    end else if (w_ingress) begin
                        n_state = S_CSUM;
                    end else if (r_hit_ok) begin
                        n_state = S_EGRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_EGRD: n_state = S_CSUM;
            S_CSUM: begin
                if (w_ingress && r_step == 3'd4) n_state = S_WRT;
                else if (w_egress && r_step == 3'd4) n_state = S_OUT;
            end
            S_WRT:  n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_valid  <= '0;
            r_idx    <= '0;
            r_rd_pend <= 1'b0;
            r_hit_ok <= 1'b0;
            r_free_ok <= 1'b0;
            r_step   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_load) r_ovalid <= 1'b1;
            else if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_in <= i_in.data;
                        r_out <= '{ACT_PASS, i_in.data.ip_saddr, i_in.data.ip_daddr,
                                   i_in.data.ip_total_length,
                                   i_in.data.ip_ttl_protocol[7:0],
                                   i_in.data.ip_checksum, i_in.data.tcp_checksum, 1'b0};
                        r_idx <= '0;
                        r_rd_pend <= 1'b0;
                        r_hit_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_step <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_idx <= LAST) begin
                        r_idx <= r_idx + 1'b1;
                        r_rd_idx <= r_idx[AW-1:0];
                    end
                    r_rd_pend <= (r_idx <= LAST);
                    if (r_rd_pend) begin
                        if (r_valid[r_rd_idx] && w_key_rd == w_lookup_key && !r_hit_ok) begin
                            r_hit_ok <= 1'b1;
                            r_hit <= r_rd_idx;
                        end
                        if (!r_valid[r_rd_idx] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free <= r_rd_idx;
                        end
                    end
                end
                S_EGRD: r_orig <= w_orig_rd;
                S_CSUM: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd0) begin
                        if (w_ingress) begin
                            r_out.action <= ACT_DECAP;
                            r_out.new_saddr <= r_in.proxy_addrs[63:32];
                            r_out.new_total_length <= r_in.ip_total_length - STRIP_BYTES;
                            r_out.new_protocol <= PROTO_TCP;
                        end else begin
                            r_out.action <= ACT_EGR;
                            r_out.new_daddr <= r_orig[63:32];
                            r_out.new_saddr <= r_orig[31:0];
                        end
                    end
                    if (w_ingress && r_step <= 3'd2) r_out.new_ip_checksum <= w_chk;
                    else if (w_egress && r_step <= 3'd1) r_out.new_ip_checksum <= w_chk;
                    else if (w_egress && r_step == 3'd4)
                        r_out.new_tcp_checksum <= r_out.new_tcp_checksum - EGRESS_ADJ;
                    else r_out.new_tcp_checksum <= w_chk;
                end
                S_WRT: begin
                    if (r_hit_ok) r_valid[r_hit] <= 1'b1;
                    else if (r_free_ok) r_valid[r_free] <= 1'b1;
                    else r_out.table_full <= 1'b1;
                end
                S_OUT: if (w_out_load) r_res <= r_out;
                default: ;
            endcase
        end
    end

    // A result that is not taken stays valid and unchanged.
    `FHR_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)),
        "result changed while stalled")
    // A result is valid in the cycle after the output state.
    `FHR_ASSERT(a_out_after_state, i_clk, i_rst_n,
        (r_state == S_OUT) |=> r_ovalid, "result not raised after output state")
    // The table is written only in the write state.
    `FHR_ASSERT(a_we_state, i_clk, i_rst_n, !w_we || r_state == S_WRT,
        "table written outside write state")
endmodule
